### rtl/prhs_pkg.sv
// shared types and constants for the raw hazard scoreboard
// no dependencies; imported by every module of the block
package prhs_pkg;

  localparam int NUM_STAGES    = 8;
  localparam int STAGE_W       = 3;
  localparam int REG_W         = 5;
  localparam int OP_W          = 3;
  localparam int REP_W         = 4;
  localparam int OUT_W         = 32;
  localparam int MAX_REPEAT    = 15;
  localparam int COUNTER_WIDTH = 32;

  // stage numbers
  localparam logic [STAGE_W-1:0] ST_IF1  = 3'd0;
  localparam logic [STAGE_W-1:0] ST_ID   = 3'd2;
  localparam logic [STAGE_W-1:0] ST_EXE1 = 3'd3;
  localparam logic [STAGE_W-1:0] ST_MEM2 = 3'd6;
  localparam logic [STAGE_W-1:0] ST_WB   = 3'd7;

  // operation codes
  localparam logic [OP_W-1:0] OP_CLOCK = 3'd0;
  localparam logic [OP_W-1:0] OP_SRC   = 3'd1;
  localparam logic [OP_W-1:0] OP_DEST  = 3'd2;
  localparam logic [OP_W-1:0] OP_FLUSH = 3'd3;
  localparam logic [OP_W-1:0] OP_STALL = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the input beat
    logic eval;   // decode and do the non-repeated part
    logic step;   // one repeated advance
    logic emit;   // snapshot the result into the output register
  } prhs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rep_zero;
  } prhs_status_t;

endpackage

### rtl/prhs_ctrl.sv
// sequencer of the raw hazard scoreboard: handshakes and command generation
// depends on prhs_pkg
module prhs_ctrl
  import prhs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  output logic         s_ready_o,
  output logic         m_valid_o,
  input  logic         m_ready_i,
  input  prhs_status_t status_i,
  output prhs_cmd_t    cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_STEP = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_q, state_d;
  logic       m_valid_q, m_valid_d;
  logic       out_free;

  assign out_free  = !m_valid_q || m_ready_i;
  assign s_ready_o = (state_q == S_IDLE);
  assign m_valid_o = m_valid_q;

  always_comb begin
    state_d   = state_q;
    m_valid_d = m_valid_q && !m_ready_i;
    cmd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = S_STEP;
      end
      S_STEP: begin
        if (status_i.rep_zero) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.emit = 1'b1;
          m_valid_d  = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

### rtl/prhs_datapath.sv
// stage slots, event counters and result register of the raw hazard scoreboard
// depends on prhs_pkg; driven by prhs_ctrl commands
module prhs_datapath
  import prhs_pkg::*;
#(
  parameter int CntW = COUNTER_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  prhs_cmd_t          cmd_i,
  input  logic [OP_W-1:0]    operation_i,
  input  logic [REG_W-1:0]   reg_index_i,
  input  logic [STAGE_W-1:0] stage_i,
  input  logic [REP_W-1:0]   repeat_count_i,
  output prhs_status_t       status_o,
  output logic [OUT_W-1:0]   cycle_count_o,
  output logic [OUT_W-1:0]   flush_count_o,
  output logic [OUT_W-1:0]   bubble_count_o,
  output logic [OUT_W-1:0]   stall_count_o,
  output logic [OUT_W-1:0]   hazard_total_o,
  output logic               hazard_found_o,
  output logic [STAGE_W-1:0] hazard_stage_o,
  output logic [STAGE_W-1:0] bubbles_added_o
);

  // captured beat
  logic [OP_W-1:0]    op_q;
  logic [REG_W-1:0]   reg_q;
  logic [STAGE_W-1:0] stg_q;
  logic [REP_W-1:0]   rep_q;

  // stage slots
  logic [NUM_STAGES-1:0] valid_q, valid_d;
  logic [REG_W-1:0]      dreg_q [NUM_STAGES];
  logic [REG_W-1:0]      dreg_d [NUM_STAGES];
  logic [STAGE_W-1:0]    rdy_q  [NUM_STAGES];
  logic [STAGE_W-1:0]    rdy_d  [NUM_STAGES];

  // counters
  logic [CntW-1:0] cycles_q, flushes_q, bubbles_q, stalls_q, hazards_q;

  // repeat control
  logic [REP_W-1:0]   rep_cnt_q, rep_cnt_d;
  logic [STAGE_W-1:0] from_q, from_d;
  logic [REP_W-1:0]   rep_sat;

  // per-item result
  logic               found_q, found_d;
  logic [STAGE_W-1:0] where_q, where_d;
  logic [STAGE_W-1:0] added_q, added_d;

  // hazard search
  logic [NUM_STAGES-1:0] hit;
  logic [4:0]            diff [NUM_STAGES];
  logic                  any_hit;
  logic [STAGE_W-1:0]    sel;
  logic [STAGE_W-1:0]    sel_bub;

  logic               adv_en;
  logic [STAGE_W-1:0] adv_from;

  assign rep_sat = (int'(rep_q) > MAX_REPEAT) ? REP_W'(MAX_REPEAT) : rep_q;

  // lanes EXE1..MEM2 each compare and work out their bubble need, lowest stage wins
  always_comb begin
    hit     = '0;
    sel     = '0;
    sel_bub = '0;
    for (int i = 0; i < NUM_STAGES; i++) begin
      diff[i] = 5'(rdy_q[i]) + 5'd2 - 5'(i) - 5'(stg_q);
      if (i >= int'(ST_EXE1) && i <= int'(ST_MEM2)) begin
        hit[i] = valid_q[i] && (dreg_q[i] == reg_q) && (reg_q != '0);
      end
    end
    for (int i = NUM_STAGES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        sel     = STAGE_W'(i);
        sel_bub = (!diff[i][4] && diff[i] != '0) ? diff[i][STAGE_W-1:0] : '0;
      end
    end
  end

  assign any_hit = |hit;

  assign adv_en   = (cmd_i.eval && op_q == OP_CLOCK) || cmd_i.step;
  assign adv_from = cmd_i.step ? from_q : stg_q;

  // slot shift from adv_from toward wb, empty slot left behind
  always_comb begin
    valid_d = valid_q;
    dreg_d  = dreg_q;
    rdy_d   = rdy_q;
    if (adv_en) begin
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (i > int'(adv_from)) begin
          valid_d[i] = valid_q[i-1];
          dreg_d[i]  = dreg_q[i-1];
          rdy_d[i]   = rdy_q[i-1];
        end
      end
      for (int i = 0; i < NUM_STAGES; i++) begin
        if (i == int'(adv_from)) begin
          valid_d[i] = 1'b0;
          dreg_d[i]  = '0;
          rdy_d[i]   = '0;
        end
      end
    end
    if (cmd_i.eval && op_q == OP_DEST) begin
      valid_d[ST_ID] = 1'b1;
      dreg_d[ST_ID]  = reg_q;
      rdy_d[ST_ID]   = stg_q;
    end
  end

  // decode of the repeated part
  always_comb begin
    rep_cnt_d = rep_cnt_q;
    from_d    = from_q;
    found_d   = found_q;
    where_d   = where_q;
    added_d   = added_q;
    if (cmd_i.eval) begin
      found_d   = 1'b0;
      where_d   = '0;
      added_d   = '0;
      rep_cnt_d = '0;
      case (op_q)
        OP_SRC: begin
          from_d = ST_EXE1;
          if (any_hit) begin
            found_d   = 1'b1;
            where_d   = sel;
            added_d   = sel_bub;
            rep_cnt_d = REP_W'(sel_bub);
          end
        end
        OP_FLUSH: begin
          from_d    = ST_IF1;
          rep_cnt_d = rep_sat;
        end
        OP_STALL: begin
          from_d    = ST_WB;
          rep_cnt_d = rep_sat;
        end
        default: begin
          from_d = from_q;
        end
      endcase
    end else if (cmd_i.step) begin
      rep_cnt_d = rep_cnt_q - REP_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= operation_i;
      reg_q <= reg_index_i;
      stg_q <= stage_i;
      rep_q <= repeat_count_i;
    end
    dreg_q  <= dreg_d;
    rdy_q   <= rdy_d;
    from_q  <= from_d;
    found_q <= found_d;
    where_q <= where_d;
    added_q <= added_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      rep_cnt_q <= '0;
      cycles_q  <= CntW'(NUM_STAGES - 1);
      flushes_q <= '0;
      bubbles_q <= '0;
      stalls_q  <= '0;
      hazards_q <= '0;
    end else begin
      valid_q   <= valid_d;
      rep_cnt_q <= rep_cnt_d;
      if (adv_en) begin
        cycles_q <= cycles_q + CntW'(1);
      end
      if (cmd_i.eval && op_q == OP_SRC && any_hit) begin
        hazards_q <= hazards_q + CntW'(1);
      end
      if (cmd_i.step) begin
        case (op_q)
          OP_SRC:   bubbles_q <= bubbles_q + CntW'(1);
          OP_FLUSH: flushes_q <= flushes_q + CntW'(1);
          OP_STALL: stalls_q  <= stalls_q + CntW'(1);
          default:  stalls_q  <= stalls_q;
        endcase
      end
    end
  end

  // result register, held until the next emit
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      cycle_count_o   <= OUT_W'(cycles_q);
      flush_count_o   <= OUT_W'(flushes_q);
      bubble_count_o  <= OUT_W'(bubbles_q);
      stall_count_o   <= OUT_W'(stalls_q);
      hazard_total_o  <= OUT_W'(hazards_q);
      hazard_found_o  <= found_q;
      hazard_stage_o  <= where_q;
      bubbles_added_o <= added_q;
    end
  end

  assign status_o.rep_zero = (rep_cnt_q == '0);

  a_step_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> rep_cnt_q != '0)
    else $error("repeat step issued with nothing left to do");

  a_step_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> rep_cnt_q == $past(rep_cnt_q) - REP_W'(1))
    else $error("repeat counter did not drop by one");

  a_step_cycle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> cycles_q == $past(cycles_q) + CntW'(1))
    else $error("cycle counter missed an advance");

  a_bubble_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && op_q == OP_SRC) |=> (added_q <= 3'd6) && (rep_cnt_q == REP_W'(added_q)))
    else $error("bubble run does not match reported bubbles");

endmodule

### rtl/pipeline_raw_hazard_scoreboard_top.sv
// top level of the raw hazard scoreboard: stream ports, controller and datapath
// depends on prhs_pkg, prhs_ctrl and prhs_datapath
//
// Scoreboard for read-after-write hazards in an eight-stage pipeline (IF1, IF2, ID,
// EXE1, EXE2, MEM1, MEM2, WB). Every input beat is one operation: clock (advance the
// slots from a given stage toward WB and leave an empty slot there), source use
// (search EXE1..MEM2 for the first pending write to the same register, count the
// hazard and insert bubbles), destination (record a write in ID), flush (repeat
// clocks from IF1) or stall (repeat clocks at WB). Each beat returns exactly one
// result beat with the wrapping event counters and the hazard outcome of a source
// use. After the input beat is accepted, the controller passes through an evaluate
// state, N repeat steps and an emit state that loads the result register, and only
// then takes the next input beat, where N is the saturated repeat count for flush
// and stall, the bubble count (0 to 6) for a source use, and 0 otherwise; each repeat
// step moves the slot array by one stage shift. Items are handled one at a time; a
// finished result waits in the output register while the next item is taken and
// worked on, and that item holds in emit until the waiting result beat has been taken.
module pipeline_raw_hazard_scoreboard_top
  import prhs_pkg::*;
#(
  parameter int CntW = COUNTER_WIDTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input beat, tdata from bit 0: operation[2:0], reg_index[7:3], stage[10:8],
  // repeat_count[14:11], zero[15]
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [15:0]  s_axis_tdata,
  // result beat, tdata from bit 0: cycle_count[31:0], flush_count[63:32],
  // bubble_count[95:64], stall_count[127:96], hazard_total[159:128],
  // hazard_found[160], hazard_stage[163:161], bubbles_added[166:164], zero[167]
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata
);

  prhs_cmd_t    cmd;
  prhs_status_t status;

  // unpacked result fields
  logic [OUT_W-1:0]   cycle_count;
  logic [OUT_W-1:0]   flush_count;
  logic [OUT_W-1:0]   bubble_count;
  logic [OUT_W-1:0]   stall_count;
  logic [OUT_W-1:0]   hazard_total;
  logic               hazard_found;
  logic [STAGE_W-1:0] hazard_stage;
  logic [STAGE_W-1:0] bubbles_added;

  // sequencing and handshakes
  prhs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // slots, counters and result register
  prhs_datapath #(
    .CntW (CntW)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .operation_i     (s_axis_tdata[2:0]),
    .reg_index_i     (s_axis_tdata[7:3]),
    .stage_i         (s_axis_tdata[10:8]),
    .repeat_count_i  (s_axis_tdata[14:11]),
    .status_o        (status),
    .cycle_count_o   (cycle_count),
    .flush_count_o   (flush_count),
    .bubble_count_o  (bubble_count),
    .stall_count_o   (stall_count),
    .hazard_total_o  (hazard_total),
    .hazard_found_o  (hazard_found),
    .hazard_stage_o  (hazard_stage),
    .bubbles_added_o (bubbles_added)
  );

  // pack the result beat, lowest field first, padded to whole bytes
  assign m_axis_tdata = {1'b0, bubbles_added, hazard_stage, hazard_found, hazard_total,
                         stall_count, bubble_count, flush_count, cycle_count};

endmodule
